FILE: rtl/edc_pkg.sv
// ----------------------------------------------------------------------------
// Elevator direction controller package
// Shared widths, codes and the types passed between the controller modules.
// ----------------------------------------------------------------------------
package edc_pkg;

	localparam int MAX_FLOORS_DEF = 16;
	localparam int FLOOR_W = 5;
	localparam int COUNT_W = 8;
	localparam int DIR_W = 2;

	localparam logic [FLOOR_W-1:0] NUM_FLOORS_RST = 5'd16;
	localparam logic [FLOOR_W-1:0] MIN_FLOORS = 5'd2;
	localparam logic [FLOOR_W-1:0] FIRST_FLOOR = 5'd1;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [DIR_W-1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic inc;
		logic clr;
		logic [FLOOR_W-1:0] inc_floor;
		logic [FLOOR_W-1:0] clr_floor;
	} cnt_ctrl_t;

	typedef struct packed {
		dir_t dir;
		logic [FLOOR_W-1:0] car;
		logic changed;
	} scan_res_t;

endpackage

FILE: rtl/edc_req_counters.sv
// ----------------------------------------------------------------------------
// Pending request counters
// One saturating counter per floor, with a flag for every floor that has
// requests waiting and the count of the floor being served.
// ----------------------------------------------------------------------------
module edc_req_counters import edc_pkg::*; #(
	parameter int MAX_FLOORS = MAX_FLOORS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cnt_ctrl_t ctrl,
	output logic [MAX_FLOORS-1:0] nz,
	output logic [COUNT_W-1:0] served
);

	localparam int IW = $clog2(MAX_FLOORS + 1);
	localparam int LW = (IW > FLOOR_W) ? IW : FLOOR_W;

	logic [COUNT_W-1:0] cnt_q [MAX_FLOORS];

	for (genvar i = 0; i < MAX_FLOORS; i++) begin : g_lane
		logic inc_hit;
		logic clr_hit;

		assign inc_hit = ctrl.inc && (LW'(ctrl.inc_floor) == LW'(i + 1));
		assign clr_hit = ctrl.clr && (LW'(ctrl.clr_floor) == LW'(i + 1));
		assign nz[i] = (cnt_q[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (clr_hit) begin
				cnt_q[i] <= '0;
			end else if (inc_hit && (cnt_q[i] != '1)) begin
				cnt_q[i] <= cnt_q[i] + 1'b1;
			end
		end
	end

	always_comb begin
		served = '0;
		for (int i = 0; i < MAX_FLOORS; i++) begin
			if (LW'(ctrl.clr_floor) == LW'(i + 1)) begin
				served = cnt_q[i];
			end
		end
	end

endmodule

FILE: rtl/edc_scan_unit.sv
// ----------------------------------------------------------------------------
// Scan direction unit
// Decides the travel direction before and after the current floor is served
// and works out the next car floor for a tick.
// ----------------------------------------------------------------------------
module edc_scan_unit import edc_pkg::*; #(
	parameter int MAX_FLOORS = MAX_FLOORS_DEF
) (
	input  logic [MAX_FLOORS-1:0] nz,
	input  logic [FLOOR_W-1:0] nf,
	input  logic [FLOOR_W-1:0] car,
	input  dir_t dir_in,
	output scan_res_t res
);

	localparam int IW = $clog2(MAX_FLOORS + 1);
	localparam int LW = (IW > FLOOR_W) ? IW : FLOOR_W;

	function automatic dir_t decide(dir_t d, logic up_any, logic dn_any);
		dir_t r;
		if (d == DIR_UP) begin
			r = up_any ? DIR_UP : DIR_DOWN;
		end else begin
			r = dn_any ? DIR_DOWN : DIR_UP;
		end
		return r;
	endfunction

	logic [MAX_FLOORS-1:0] live;
	logic [MAX_FLOORS-1:0] left;
	logic [MAX_FLOORS-1:0] above;
	logic [MAX_FLOORS-1:0] below;
	dir_t d1;
	dir_t d2;

	always_comb begin
		for (int i = 0; i < MAX_FLOORS; i++) begin
			live[i] = nz[i] && (LW'(i + 1) <= LW'(nf));
			above[i] = LW'(i + 1) > LW'(car);
			below[i] = LW'(i + 1) < LW'(car);
			left[i] = live[i] && (LW'(i + 1) != LW'(car));
		end
	end

	always_comb begin
		d1 = decide(dir_in, |(live & above), |(live & below));
		d2 = decide(d1, |(left & above), |(left & below));
		if (left == '0) begin
			d2 = DIR_IDLE;
		end
		res.dir = d2;
		res.car = car;
		res.changed = 1'b0;
		if ((d2 == DIR_UP) && (car < nf)) begin
			res.car = car + 1'b1;
			res.changed = (dir_in != DIR_UP);
		end else if ((d2 == DIR_DOWN) && (car > FIRST_FLOOR)) begin
			res.car = car - 1'b1;
			res.changed = (dir_in != DIR_DOWN);
		end
	end

endmodule

FILE: rtl/elevator_direction_controller_top.sv
// ----------------------------------------------------------------------------
// Elevator direction controller
// Scan scheme car controller with per-floor request counts and one result
// for every request or tick.
// ----------------------------------------------------------------------------
// The controller takes one item per clock cycle while the output register can
// advance; a stalled result holds the input register. An accepted item is
// captured in the input register; when it fires, the floor counters, the scan
// logic and the car state are updated together while the result is loaded into
// the output register. Each floor has its own counter, so a request and the
// scans over all floors are handled together in that step. The floor count
// register may be written only while no request is in flight.
module elevator_direction_controller_top import edc_pkg::*; #(
	parameter int MAX_FLOORS = MAX_FLOORS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [FLOOR_W-1:0] wr_data,
	input  logic item_valid,
	output logic item_ready,
	input  logic kind,
	input  logic [FLOOR_W-1:0] floor,
	output logic result_valid,
	input  logic result_ready,
	output logic [COUNT_W-1:0] served_count,
	output logic [FLOOR_W-1:0] car_floor,
	output logic [DIR_W-1:0] direction,
	output logic direction_changed
);

	localparam int IW = $clog2(MAX_FLOORS + 1);
	localparam int LW = (IW > FLOOR_W) ? IW : FLOOR_W;

	logic valid_s1;
	logic kind_s1;
	logic [FLOOR_W-1:0] floor_s1;
	logic [FLOOR_W-1:0] num_floors_q;
	logic [FLOOR_W-1:0] car_q;
	dir_t dir_q;
	logic out_valid_q;
	logic [COUNT_W-1:0] served_q;
	logic [FLOOR_W-1:0] car_out_q;
	dir_t dir_out_q;
	logic changed_q;

	logic advance;
	logic fire;
	logic is_tick;
	logic [FLOOR_W-1:0] nf;
	logic [FLOOR_W-1:0] car_c;
	cnt_ctrl_t ctrl;
	logic [MAX_FLOORS-1:0] nz;
	logic [COUNT_W-1:0] served;
	scan_res_t res;

	assign advance = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;
	assign is_tick = (kind_s1 == KIND_TICK);

	always_comb begin
		if (num_floors_q < MIN_FLOORS) begin
			nf = MIN_FLOORS;
		end else if (LW'(num_floors_q) > LW'(MAX_FLOORS)) begin
			nf = FLOOR_W'(MAX_FLOORS);
		end else begin
			nf = num_floors_q;
		end
		car_c = (car_q > nf) ? nf : car_q;
	end

	always_comb begin
		ctrl.inc = fire && (kind_s1 == KIND_REQUEST) && (floor_s1 != '0) && (floor_s1 <= nf);
		ctrl.clr = fire && is_tick;
		ctrl.inc_floor = floor_s1;
		ctrl.clr_floor = car_c;
	end

	edc_req_counters #(
		.MAX_FLOORS(MAX_FLOORS)
	) u_counters (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.nz(nz),
		.served(served)
	);

	edc_scan_unit #(
		.MAX_FLOORS(MAX_FLOORS)
	) u_scan (
		.nz(nz),
		.nf(nf),
		.car(car_c),
		.dir_in(dir_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			kind_s1 <= kind;
			floor_s1 <= floor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_floors_q <= NUM_FLOORS_RST;
		end else if (wr_en) begin
			num_floors_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q <= FIRST_FLOOR;
			dir_q <= DIR_IDLE;
		end else if (fire && is_tick) begin
			car_q <= res.car;
			dir_q <= res.dir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_tick) begin
				served_q <= served;
				car_out_q <= res.car;
				dir_out_q <= res.dir;
				changed_q <= res.changed;
			end else begin
				served_q <= '0;
				car_out_q <= car_q;
				dir_out_q <= dir_q;
				changed_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign served_count = served_q;
	assign car_floor = car_out_q;
	assign direction = dir_out_q;
	assign direction_changed = changed_q;

endmodule

FILE: rtl/edc_checker.sv
// ----------------------------------------------------------------------------
// Elevator direction controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module edc_checker import edc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic result_valid,
	input  logic result_ready,
	input  logic [COUNT_W-1:0] served_count,
	input  logic [FLOOR_W-1:0] car_floor,
	input  logic [DIR_W-1:0] direction,
	input  logic direction_changed
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("Result withdrawn before it was taken.");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(served_count) && $stable(car_floor)
			&& $stable(direction) && $stable(direction_changed))
		else $error("Result payload changed while stalled.");

	a_car_on_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> car_floor != '0)
		else $error("Car reported below the first floor.");

	a_change_moves: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && direction_changed |-> direction != DIR_IDLE)
		else $error("Direction change reported while the car is idle.");

endmodule

bind elevator_direction_controller_top edc_checker u_edc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.served_count(served_count),
	.car_floor(car_floor),
	.direction(direction),
	.direction_changed(direction_changed)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Elevator direction controller testbench
// Drives floor requests and ticks through the valid/ready request channel,
// keeps its own scan model of the per-floor counts, car floor and direction,
// and compares every returned car report field by field. The floor count is
// changed between phases, including values below and above the legal range,
// and each phase sets its mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import edc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic kind;
		logic [FLOOR_W-1:0] floor;
	} floor_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] served;
		logic [FLOOR_W-1:0] car;
		dir_t dir;
		logic changed;
	} car_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [FLOOR_W-1:0] wr_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic kind = 1'b0;
	logic [FLOOR_W-1:0] floor = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [COUNT_W-1:0] served_count;
	logic [FLOOR_W-1:0] car_floor;
	logic [DIR_W-1:0] direction;
	logic direction_changed;

	floor_item_t pending_items[$];
	car_report_t car_reports_due[$];

	logic [COUNT_W-1:0] floor_calls [1:MAX_FLOORS_DEF];
	int model_car;
	dir_t model_dir;
	logic [FLOOR_W-1:0] model_floor_count;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit req_taken = 1'b0;
	int fail_count = 0;
	int stuck_cycles = 0;

	elevator_direction_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.kind(kind),
		.floor(floor),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.served_count(served_count),
		.car_floor(car_floor),
		.direction(direction),
		.direction_changed(direction_changed)
	);

	always #1 clk = ~clk;

	function automatic int floors_in_effect();
		int n;
		n = int'(model_floor_count);
		if (n < MIN_FLOORS) n = int'(MIN_FLOORS);
		if (n > MAX_FLOORS_DEF) n = MAX_FLOORS_DEF;
		return n;
	endfunction

	function automatic bit calls_between(int lo, int hi);
		for (int f = lo; f <= hi && f >= 1 && f <= MAX_FLOORS_DEF; f++) begin
			if (floor_calls[f] != '0) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic dir_t next_heading(dir_t dir, int car, int nf);
		if (dir == DIR_UP)
			return (car < nf && calls_between(car + 1, nf)) ? DIR_UP : DIR_DOWN;
		return (car > 1 && calls_between(1, car - 1)) ? DIR_DOWN : DIR_UP;
	endfunction

	task automatic predict_car_report(input logic k, input logic [FLOOR_W-1:0] fl);
		int nf;
		dir_t prev;
		dir_t dir;
		car_report_t rep;
		nf = floors_in_effect();
		rep = '0;
		if (k == KIND_REQUEST) begin
			if (fl >= 1 && fl <= nf && floor_calls[fl] != '1)
				floor_calls[fl] = floor_calls[fl] + 1'b1;
		end else begin
			prev = model_dir;
			if (model_car > nf) model_car = nf;
			if (model_car < 1) model_car = 1;
			dir = next_heading(model_dir, model_car, nf);
			rep.served = floor_calls[model_car];
			floor_calls[model_car] = '0;
			dir = next_heading(dir, model_car, nf);
			if (!calls_between(1, nf)) dir = DIR_IDLE;
			if (dir == DIR_UP && model_car < nf) begin
				rep.changed = (prev != DIR_UP);
				model_car++;
			end else if (dir == DIR_DOWN && model_car > 1) begin
				rep.changed = (prev != DIR_DOWN);
				model_car--;
			end
			model_dir = dir;
		end
		rep.car = FLOOR_W'(model_car);
		rep.dir = model_dir;
		car_reports_due.push_back(rep);
	endtask

	// New requests are presented on the falling edge; a request already on the
	// channel is held until the monitor has seen it accepted.
	always @(negedge clk) begin
		floor_item_t nxt;
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && (!item_valid || req_taken)) begin
			req_taken = 1'b0;
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				kind <= nxt.kind;
				floor <= nxt.floor;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		car_report_t due;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				moved = 1'b1;
				if (car_reports_due.size() == 0) begin
					$error("car report with no prediction waiting");
					fail_count++;
				end else begin
					due = car_reports_due.pop_front();
					if (served_count !== due.served) begin
						$error("served_count: expected %0d, got %0d", due.served, served_count);
						fail_count++;
					end
					if (car_floor !== due.car) begin
						$error("car_floor: expected %0d, got %0d", due.car, car_floor);
						fail_count++;
					end
					if (direction !== due.dir) begin
						$error("direction: expected %0d, got %0d", due.dir, direction);
						fail_count++;
					end
					if (direction_changed !== due.changed) begin
						$error("direction_changed: expected %0d, got %0d", due.changed,
							direction_changed);
						fail_count++;
					end
				end
			end
			if (item_valid && item_ready) begin
				moved = 1'b1;
				predict_car_report(kind, floor);
				req_taken = 1'b1;
			end
			if (moved || !(pending_items.size() != 0 || item_valid ||
					car_reports_due.size() != 0)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= WATCHDOG_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	task automatic push_request(input logic [FLOOR_W-1:0] f);
		pending_items.push_back('{kind: KIND_REQUEST, floor: f});
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			pending_items.push_back('{kind: KIND_TICK, floor: FLOOR_W'($urandom_range(31))});
	endtask

	task automatic push_random_traffic(input int n);
		int r;
		int nf;
		nf = floors_in_effect();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45)
				push_ticks(1);
			else if (r < 92)
				push_request(FLOOR_W'($urandom_range(nf, 1)));
			else
				push_request(FLOOR_W'($urandom_range(31)));
		end
	endtask

	task automatic wait_all_reports();
		while (pending_items.size() != 0 || item_valid || car_reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_floor_count(input logic [FLOOR_W-1:0] v);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		model_floor_count = v;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		for (int f = 1; f <= MAX_FLOORS_DEF; f++) floor_calls[f] = '0;
		model_car = int'(FIRST_FLOOR);
		model_dir = DIR_IDLE;
		model_floor_count = NUM_FLOORS_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_floor_count(5'd16);
		set_idling(0, 0);
		// Empty building, requests outside it, then a short ride up and back.
		push_ticks(1);
		push_request(5'd0);
		push_request(5'd17);
		push_request(5'd31);
		push_request(5'd16);
		push_request(5'd1);
		push_request(5'd1);
		push_ticks(3);
		push_request(5'd1);
		push_request(5'd8);
		push_ticks(6);
		push_request(5'd2);
		push_ticks(5);
		wait_all_reports();
		push_random_traffic(100);
		wait_all_reports();

		write_floor_count(5'd2);
		set_idling(58, 0);
		push_random_traffic(100);
		wait_all_reports();

		write_floor_count(5'd0);
		set_idling(0, 58);
		push_random_traffic(100);
		wait_all_reports();

		write_floor_count(5'd31);
		set_idling(22, 22);
		push_random_traffic(50);
		// Drive one floor count into saturation, then let the car collect it.
		for (int i = 0; i < 260; i++) push_request(5'd5);
		push_ticks(20);
		// Send the car towards the top before the building shrinks.
		push_request(5'd15);
		push_request(5'd16);
		push_request(5'd16);
		push_ticks(20);
		wait_all_reports();

		write_floor_count(5'd4);
		set_idling(58, 0);
		push_ticks(1);
		push_random_traffic(150);
		wait_all_reports();

		write_floor_count(5'd1);
		set_idling(0, 58);
		push_random_traffic(100);
		wait_all_reports();

		write_floor_count(5'd17);
		set_idling(22, 22);
		push_random_traffic(150);
		wait_all_reports();

		write_floor_count(FLOOR_W'($urandom_range(MAX_FLOORS_DEF, MIN_FLOORS)));
		set_idling(0, 0);
		push_random_traffic(100);
		wait_all_reports();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && car_reports_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: elevator_direction_controller_top.f
rtl/edc_pkg.sv
rtl/edc_req_counters.sv
rtl/edc_scan_unit.sv
rtl/elevator_direction_controller_top.sv
rtl/edc_checker.sv
tb/tb_top.sv
